// File: hw/rtl/vog_pkg.sv
// Shared types and constants for the voxel occupancy grid.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package vog_pkg;

    localparam int unsigned X_CELLS_DEF = 64;
    localparam int unsigned Y_CELLS_DEF = 64;
    localparam int unsigned Z_CELLS_DEF = 64;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned CELL_W    = 6;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_W     = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Z  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL     = 4'd7;

    localparam logic [CFG_W-1:0] INV_CELL_RST = 32'h0001_0000;
    localparam logic [CFG_W-1:0] CELL_RST     = 32'h0001_0000;

    // Request codes.
    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Address width for a count of entries, never below one bit.
    function automatic int unsigned addr_w(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    typedef struct packed {
        logic load_in;
        logic mul;
        logic idx;
        logic finish;
        logic clr_we;
    } t_vog_cmd;

    typedef struct packed {
        logic clr_last;
    } t_vog_sts;

endpackage

// File: hw/rtl/vog_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the occupancy rows of the grid.
`timescale 1ns / 1ps

module vog_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/vog_ctrl.sv
// Controller of the voxel occupancy grid: clearing pass, item sequencing and
// the output valid flag. Depends on vog_pkg for the command and status structs.
`timescale 1ns / 1ps

module vog_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output vog_pkg::t_vog_cmd o_cmd,
    input  vog_pkg::t_vog_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MUL,
        S_IDX,
        S_WB
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   wb_go;

    // The last stage waits only while the previous result is still held.
    assign wb_go = (r_state == S_WB) && !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_IDX;
                S_IDX: r_state <= S_WB;
                S_WB: begin
                    if (wb_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLR;
            endcase

            if (wb_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd.load_in = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul     = (r_state == S_MUL);
        o_cmd.idx     = (r_state == S_IDX);
        o_cmd.finish  = wb_go;
        o_cmd.clr_we  = (r_state == S_CLR);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/vog_datapath.sv
// Datapath of the voxel occupancy grid: configuration registers, offset and
// index arithmetic, cell centers, the occupancy RAM and the result register.
// Depends on vog_pkg and vog_ram.
`timescale 1ns / 1ps

module vog_datapath #(
    parameter int unsigned X_CELLS = vog_pkg::X_CELLS_DEF,
    parameter int unsigned Y_CELLS = vog_pkg::Y_CELLS_DEF,
    parameter int unsigned Z_CELLS = vog_pkg::Z_CELLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vog_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vog_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_req_type,
    input  logic signed [vog_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vog_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vog_pkg::COORD_W-1:0] i_coord_z,
    input  vog_pkg::t_vog_cmd                  i_cmd,
    output vog_pkg::t_vog_sts                  o_sts,
    output logic                               o_in_bounds,
    output logic                               o_is_free,
    output logic [vog_pkg::CELL_W-1:0]         o_cell_x,
    output logic [vog_pkg::CELL_W-1:0]         o_cell_y,
    output logic [vog_pkg::CELL_W-1:0]         o_cell_z,
    output logic signed [vog_pkg::COORD_W-1:0] o_center_x,
    output logic signed [vog_pkg::COORD_W-1:0] o_center_y,
    output logic signed [vog_pkg::COORD_W-1:0] o_center_z
);

    localparam int unsigned CW    = vog_pkg::COORD_W;
    localparam int unsigned XW    = vog_pkg::addr_w(X_CELLS);
    localparam int unsigned YW    = vog_pkg::addr_w(Y_CELLS);
    localparam int unsigned ZW    = vog_pkg::addr_w(Z_CELLS);
    localparam int unsigned IW    = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
    localparam int unsigned DEPTH = X_CELLS * Y_CELLS;
    localparam int unsigned RW    = vog_pkg::addr_w(DEPTH);
    localparam logic [CW-1:0] SIZE [3] = '{CW'(X_CELLS), CW'(Y_CELLS), CW'(Z_CELLS)};

    // Configuration.
    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_lim [3];
    logic [CW-1:0]        r_inv;
    logic [CW-1:0]        r_csz;

    // Item registers.
    logic                 r_req;
    logic                 r_inside;
    logic                 r_neg [3];
    logic [CW-1:0]        r_mag [3];
    logic [CW-1:0]        r_q   [3];
    logic [IW-1:0]        r_idx [3];
    logic [CW-1:0]        r_half [3];
    logic                 r_ok;
    logic [RW-1:0]        r_row;
    logic [RW-1:0]        r_clr;

    // Result register.
    logic                 r_out_in_bounds;
    logic                 r_out_is_free;
    logic [vog_pkg::CELL_W-1:0] r_out_cell [3];
    logic [CW-1:0]        r_out_center [3];

    logic signed [CW-1:0] coord [3];
    logic signed [CW:0]   off   [3];
    logic [CW:0]          off_abs [3];
    logic                 lim_ok [3];
    logic [2*CW-1:0]      prod  [3];
    logic [IW-1:0]        idx_c [3];
    logic                 ok_c  [3];
    logic [2*CW-1:0]      half_prod [3];
    logic [15:0]          idx_ext [3];
    logic [RW-1:0]        row_c;

    logic                 ram_we;
    logic [RW-1:0]        ram_waddr;
    logic [Z_CELLS-1:0]   ram_wdata;
    logic [Z_CELLS-1:0]   ram_rdata;
    logic                 cell_bit;
    logic [ZW-1:0]        zsel;

    assign coord[0] = i_coord_x;
    assign coord[1] = i_coord_y;
    assign coord[2] = i_coord_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            off[a]     = {coord[a][CW-1], coord[a]} - {r_org[a][CW-1], r_org[a]};
            off_abs[a] = off[a][CW] ? (CW+1)'(-off[a]) : off[a];
            lim_ok[a]  = !off[a][CW] && (coord[a] < r_lim[a]);
            prod[a]    = (2*CW)'(r_mag[a]) * (2*CW)'(r_inv);

            // A negative offset clamps to zero; it is only out of range when
            // it spans at least one whole cell.
            if (r_neg[a]) begin
                idx_c[a] = '0;
                ok_c[a]  = (r_q[a] == '0);
            end else if (r_q[a] >= SIZE[a]) begin
                idx_c[a] = IW'(SIZE[a] - CW'(1));
                ok_c[a]  = 1'b0;
            end else begin
                idx_c[a] = IW'(r_q[a]);
                ok_c[a]  = 1'b1;
            end

            half_prod[a] = (2*CW)'({idx_c[a], 1'b1}) * (2*CW)'(r_csz);
            idx_ext[a]   = 16'(r_idx[a]);
        end
        row_c = RW'(RW'(idx_c[0]) * RW'(Y_CELLS)) + RW'(idx_c[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_org[a] <= '0;
                r_lim[a] <= '0;
            end
            r_inv <= vog_pkg::INV_CELL_RST;
            r_csz <= vog_pkg::CELL_RST;
            r_clr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vog_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                    vog_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                    vog_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                    vog_pkg::CFG_LIMIT_X:  r_lim[0] <= i_cfg_data;
                    vog_pkg::CFG_LIMIT_Y:  r_lim[1] <= i_cfg_data;
                    vog_pkg::CFG_LIMIT_Z:  r_lim[2] <= i_cfg_data;
                    vog_pkg::CFG_INV_CELL: r_inv    <= i_cfg_data;
                    vog_pkg::CFG_CELL:     r_csz    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req    <= i_req_type;
            r_inside <= lim_ok[0] && lim_ok[1] && lim_ok[2];
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= off[a][CW];
                r_mag[a] <= off_abs[a][CW-1:0];
            end
        end
        if (i_cmd.mul) begin
            for (int a = 0; a < 3; a++) begin
                r_q[a] <= prod[a][2*CW-1:CW];
            end
        end
        if (i_cmd.idx) begin
            r_ok  <= ok_c[0] && ok_c[1] && ok_c[2];
            r_row <= row_c;
            for (int a = 0; a < 3; a++) begin
                r_idx[a]  <= idx_c[a];
                r_half[a] <= half_prod[a][CW:1];
            end
        end
        if (i_cmd.finish) begin
            r_out_in_bounds <= (r_req == vog_pkg::REQ_QUERY) ? r_ok : (r_inside && r_ok);
            r_out_is_free   <= (r_req == vog_pkg::REQ_QUERY) && !cell_bit;
            for (int a = 0; a < 3; a++) begin
                r_out_cell[a]   <= idx_ext[a][vog_pkg::CELL_W-1:0];
                r_out_center[a] <= r_half[a] + r_org[a];
            end
        end
    end

    assign o_sts.clr_last = (r_clr == RW'(DEPTH - 1));

    // The read address follows the row under computation, so the row data is
    // ready in the write-back cycle and stays put while that cycle waits.
    assign zsel      = r_idx[2][ZW-1:0];
    assign cell_bit  = ram_rdata[zsel];
    assign ram_we    = i_cmd.clr_we ||
                       (i_cmd.finish && (r_req == vog_pkg::REQ_SET) && r_inside && r_ok);
    assign ram_waddr = i_cmd.clr_we ? r_clr : r_row;
    assign ram_wdata = i_cmd.clr_we ? '0 : (ram_rdata | (Z_CELLS'(1) << zsel));

    vog_ram #(
        .WIDTH (Z_CELLS),
        .DEPTH (DEPTH),
        .AW    (RW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (row_c),
        .o_rdata (ram_rdata)
    );

    assign o_in_bounds = r_out_in_bounds;
    assign o_is_free   = r_out_is_free;
    assign o_cell_x    = r_out_cell[0];
    assign o_cell_y    = r_out_cell[1];
    assign o_cell_z    = r_out_cell[2];
    assign o_center_x  = r_out_center[0];
    assign o_center_y  = r_out_center[1];
    assign o_center_z  = r_out_center[2];

endmodule

// File: hw/rtl/voxel_occupancy_grid_unit.sv
// Voxel occupancy grid: one occupancy bit per cell, stored as rows of
// Z_CELLS bits, X_CELLS * Y_CELLS rows deep. After reset the block clears
// one row per cycle and keeps its input stalled until that pass is done;
// configuration writes are taken meanwhile. Each request is then worked
// on alone, in steps: offset and bounds on accept, the index multiply,
// clamping with the center multiply and the row read, then write-back into
// the row and the result register; write-back waits while the previous
// result is still held by the output stall. The two dependent multiplies
// and the registered row read lie ahead of the row update. A finished
// result waits in the output register while the next request is accepted.
// Depends on vog_pkg, vog_ctrl and vog_datapath.
`timescale 1ns / 1ps

module voxel_occupancy_grid_unit #(
    parameter int unsigned X_CELLS = vog_pkg::X_CELLS_DEF,
    parameter int unsigned Y_CELLS = vog_pkg::Y_CELLS_DEF,
    parameter int unsigned Z_CELLS = vog_pkg::Z_CELLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vog_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vog_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic signed [vog_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vog_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vog_pkg::COORD_W-1:0] i_coord_z,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_in_bounds,
    output logic                               o_is_free,
    output logic [vog_pkg::CELL_W-1:0]         o_cell_x,
    output logic [vog_pkg::CELL_W-1:0]         o_cell_y,
    output logic [vog_pkg::CELL_W-1:0]         o_cell_z,
    output logic signed [vog_pkg::COORD_W-1:0] o_center_x,
    output logic signed [vog_pkg::COORD_W-1:0] o_center_y,
    output logic signed [vog_pkg::COORD_W-1:0] o_center_z
);

    vog_pkg::t_vog_cmd cmd;
    vog_pkg::t_vog_sts sts;

    vog_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    vog_datapath #(
        .X_CELLS (X_CELLS),
        .Y_CELLS (Y_CELLS),
        .Z_CELLS (Z_CELLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_in_bounds (o_in_bounds),
        .o_is_free   (o_is_free),
        .o_cell_x    (o_cell_x),
        .o_cell_y    (o_cell_y),
        .o_cell_z    (o_cell_z),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_center_z  (o_center_z)
    );

endmodule

// File: hw/rtl/vog_checker.sv
// Port-level checks for the voxel occupancy grid, bound to the top level.
// Depends on vog_pkg for field widths.
`timescale 1ns / 1ps

module vog_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [vog_pkg::COORD_W-1:0] o_center_x,
    input logic [vog_pkg::CELL_W-1:0]         o_cell_x
);

    // A held result keeps its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_center_x) && $stable(o_cell_x)))
        else $error("result beat changed while stalled");

    // Reset starts the clearing pass, so no request may enter right after it.
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("input open or result shown right after reset");

    // Only one request is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request accepted while one is in flight");

    // No result is shown while the accepted request is in its multiply, index and write-back steps.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=>
            (!o_out_valid ##1 !o_out_valid ##1 !o_out_valid))
        else $error("result appeared too early");

endmodule

bind voxel_occupancy_grid_unit vog_checker u_vog_checker (.*);
